>>> sv/bhp_pkg.sv
`timescale 1ns / 1ps

package bhp_pkg;

	// Parser phases, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_HEADER  = 5'b00010,
		PH_PALETTE = 5'b00100,
		PH_SKIP    = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_FORMAT  = 2'd1,
		ST_BAD_PIXEL   = 2'd2,
		ST_UNSUPPORTED = 2'd3
	} status_t;

	// Byte offsets in the file where a header field completes.
	localparam logic [5:0] IDX_MAGIC_B     = 6'd0;
	localparam logic [5:0] IDX_MAGIC_M     = 6'd1;
	localparam logic [5:0] IDX_FILE_SIZE   = 6'd5;
	localparam logic [5:0] IDX_DATA_OFFSET = 6'd13;
	localparam logic [5:0] IDX_INFO_SIZE   = 6'd17;
	localparam logic [5:0] IDX_WIDTH       = 6'd21;
	localparam logic [5:0] IDX_HEIGHT      = 6'd25;
	localparam logic [5:0] IDX_PLANES      = 6'd27;
	localparam logic [5:0] IDX_BITS        = 6'd29;
	localparam logic [5:0] IDX_COMPRESSION = 6'd33;
	localparam logic [5:0] IDX_COLORS_USED = 6'd49;
	localparam logic [5:0] IDX_LAST        = 6'd53;

	localparam logic [7:0]  MAGIC_B         = 8'h42;
	localparam logic [7:0]  MAGIC_M         = 8'h4D;
	localparam logic [31:0] MIN_HEADER      = 32'd54;
	localparam logic [10:0] MIN_HEADER_11   = 11'd54;
	localparam logic [31:0] INFO_SIZE       = 32'd40;
	localparam logic [15:0] MAX_DIM_RESET   = 16'd16384;
	localparam logic [12:0] BPP_GRAY        = 13'd1;
	localparam logic [12:0] BPP_COLOR       = 13'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] width;
		logic signed [31:0] height;
		logic [12:0]        bytes_per_pixel;
		logic [8:0]         palette_entries;
	} result_t;

endpackage

>>> sv/bhp_if.sv
`timescale 1ns / 1ps

// Byte stream channel into the parser.
interface bhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_req;

	modport source (output valid, output data_byte, output start_req, input ready);
	modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

// Result channel out of the parser.
interface bhp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] width;
	logic signed [31:0] height;
	logic [12:0]        bytes_per_pixel;
	logic [8:0]         palette_entries;

	modport source (output valid, output status, output width, output height,
		output bytes_per_pixel, output palette_entries, input ready);
	modport sink (input valid, input status, input width, input height,
		input bytes_per_pixel, input palette_entries, output ready);
endinterface

>>> sv/bhp_parser.sv
`timescale 1ns / 1ps

module bhp_parser import bhp_pkg::*; #(
	parameter int MAX_COLORS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	input  logic [15:0] max_dimension,
	output logic        res_valid,
	output result_t     res
);

	localparam logic [8:0]  MAX_COLORS_9  = 9'(MAX_COLORS);
	localparam logic [31:0] MAX_COLORS_32 = 32'(MAX_COLORS);

	logic [5:0]  byte_index_q;
	logic [31:0] field_accum_q;
	logic [31:0] header_offset_q;
	logic [31:0] image_width_q;
	logic [31:0] image_height_q;
	logic [12:0] pixel_bytes_q;
	logic [8:0]  color_count_q;
	logic        colors_bad_q;
	logic [9:0]  palette_byte_count_q;
	logic [7:0]  blue_latch_q;
	logic        all_gray_q;
	logic [31:0] skip_count_q;
	phase_t      phase_q;

	// Working copy of the state: reset to its start values when the request starts a new file.
	logic [5:0]  b_idx;
	logic [31:0] b_acc, b_off, b_w, b_h, b_skip;
	logic [12:0] b_pb;
	logic [8:0]  b_cc;
	logic        b_ccbad, b_gray;
	logic [9:0]  b_pbc;
	logic [7:0]  b_blue;
	phase_t      b_phase;

	always_comb begin
		if (start_req) begin
			b_idx   = '0;
			b_acc   = '0;
			b_off   = '0;
			b_w     = '0;
			b_h     = '0;
			b_pb    = '0;
			b_cc    = '0;
			b_ccbad = 1'b0;
			b_pbc   = '0;
			b_blue  = '0;
			b_gray  = 1'b1;
			b_skip  = '0;
			b_phase = PH_HEADER;
		end else begin
			b_idx   = byte_index_q;
			b_acc   = field_accum_q;
			b_off   = header_offset_q;
			b_w     = image_width_q;
			b_h     = image_height_q;
			b_pb    = pixel_bytes_q;
			b_cc    = color_count_q;
			b_ccbad = colors_bad_q;
			b_pbc   = palette_byte_count_q;
			b_blue  = blue_latch_q;
			b_gray  = all_gray_q;
			b_skip  = skip_count_q;
			b_phase = phase_q;
		end
	end

	// Derived values used by the header and palette phases.
	logic [31:0] acc_new;
	logic [8:0]  cc_eff;
	logic [10:0] used_hdr, used_pal;
	logic [31:0] skip_hdr, skip_pal;
	logic        pal_last, over_w, over_h, pb_bad;

	assign acc_new  = {data_byte, b_acc[31:8]};
	assign cc_eff   = (b_cc == 9'd0 && b_pb == BPP_GRAY) ? MAX_COLORS_9 : b_cc;
	assign used_hdr = MIN_HEADER_11 + {cc_eff, 2'b00};
	assign used_pal = MIN_HEADER_11 + {b_cc, 2'b00};
	assign skip_hdr = b_off - 32'(used_hdr);
	assign skip_pal = b_off - 32'(used_pal);
	assign pal_last = ({1'b0, b_pbc} + 11'd1) >= {b_cc, 2'b00};
	assign over_w   = !b_w[31] && (b_w > {16'd0, max_dimension});
	assign over_h   = !b_h[31] && (b_h > {16'd0, max_dimension});
	assign pb_bad   = (b_pb != BPP_GRAY) && (b_pb != BPP_COLOR);

	logic [5:0]  n_idx;
	logic [31:0] n_acc, n_off, n_w, n_h, n_skip;
	logic [12:0] n_pb;
	logic [8:0]  n_cc;
	logic        n_ccbad, n_gray;
	logic [9:0]  n_pbc;
	logic [7:0]  n_blue;
	phase_t      n_phase;
	logic        give;
	logic [1:0]  give_status;
	logic        give_ok;

	// Next state and result for one byte.
	always_comb begin
		n_idx       = b_idx;
		n_acc       = b_acc;
		n_off       = b_off;
		n_w         = b_w;
		n_h         = b_h;
		n_pb        = b_pb;
		n_cc        = b_cc;
		n_ccbad     = b_ccbad;
		n_pbc       = b_pbc;
		n_blue      = b_blue;
		n_gray      = b_gray;
		n_skip      = b_skip;
		n_phase     = b_phase;
		give        = 1'b0;
		give_status = ST_OK;
		give_ok     = 1'b0;

		case (b_phase)
			PH_HEADER: begin
				n_acc = acc_new;
				n_idx = b_idx + 6'd1;
				case (b_idx)
					IDX_MAGIC_B: begin
						if (data_byte != MAGIC_B) begin
							give        = 1'b1;
							give_status = ST_BAD_FORMAT;
						end
					end
					IDX_MAGIC_M: begin
						if (data_byte != MAGIC_M) begin
							give        = 1'b1;
							give_status = ST_BAD_FORMAT;
						end
					end
					IDX_FILE_SIZE: begin
						if (acc_new < MIN_HEADER) begin
							give        = 1'b1;
							give_status = ST_BAD_FORMAT;
						end
					end
					IDX_DATA_OFFSET: begin
						n_off = acc_new;
						if (acc_new < MIN_HEADER) begin
							give        = 1'b1;
							give_status = ST_BAD_FORMAT;
						end
					end
					IDX_INFO_SIZE: begin
						if (acc_new != INFO_SIZE) begin
							give        = 1'b1;
							give_status = ST_BAD_FORMAT;
						end
					end
					IDX_WIDTH: begin
						n_w = acc_new;
						if (acc_new == 32'd0) begin
							give        = 1'b1;
							give_status = ST_BAD_PIXEL;
						end
					end
					IDX_HEIGHT: begin
						n_h = acc_new;
						if (acc_new == 32'd0) begin
							give        = 1'b1;
							give_status = ST_BAD_PIXEL;
						end
					end
					IDX_PLANES: begin
						if (acc_new[31:16] != 16'd1) begin
							give        = 1'b1;
							give_status = ST_BAD_PIXEL;
						end
					end
					IDX_BITS: begin
						n_pb = acc_new[31:19];
						if (acc_new[31:19] == 13'd0) begin
							give        = 1'b1;
							give_status = ST_BAD_PIXEL;
						end
					end
					IDX_COMPRESSION: begin
						if (acc_new != 32'd0) begin
							give        = 1'b1;
							give_status = ST_UNSUPPORTED;
						end
					end
					IDX_COLORS_USED: begin
						n_ccbad = acc_new > MAX_COLORS_32;
						n_cc    = acc_new[8:0];
					end
					IDX_LAST: begin
						if (over_w || over_h || pb_bad) begin
							give        = 1'b1;
							give_status = ST_BAD_PIXEL;
						end else if (b_ccbad || b_off < 32'(used_hdr)) begin
							give        = 1'b1;
							give_status = ST_UNSUPPORTED;
						end else if (cc_eff != 9'd0) begin
							n_cc    = cc_eff;
							n_pbc   = '0;
							n_phase = PH_PALETTE;
						end else begin
							// No palette: go straight to padding or finish.
							n_skip = skip_hdr;
							if (skip_hdr == 32'd0) begin
								give    = 1'b1;
								give_ok = 1'b1;
							end else begin
								n_phase = PH_SKIP;
							end
						end
					end
					default: begin
					end
				endcase
			end
			PH_PALETTE: begin
				// Track whether every entry has blue equal to green and red.
				if (b_pbc[1:0] == 2'd0) begin
					n_blue = data_byte;
				end else if (b_pbc[1:0] != 2'd3 && data_byte != b_blue) begin
					n_gray = 1'b0;
				end
				if (pal_last) begin
					if (b_pb == BPP_GRAY && !n_gray) begin
						n_pb = BPP_COLOR;
					end
					n_skip = skip_pal;
					if (skip_pal == 32'd0) begin
						give    = 1'b1;
						give_ok = 1'b1;
					end else begin
						n_phase = PH_SKIP;
					end
				end else begin
					n_pbc = b_pbc + 10'd1;
				end
			end
			PH_SKIP: begin
				n_skip = b_skip - 32'd1;
				if (n_skip == 32'd0) begin
					give    = 1'b1;
					give_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (give) begin
			n_phase = PH_DONE;
		end
	end

	// Result fields other than status are zero on an error.
	assign res_valid           = step && give;
	assign res.status          = give_status;
	assign res.width           = give_ok ? n_w : '0;
	assign res.height          = give_ok ? n_h : '0;
	assign res.bytes_per_pixel = give_ok ? n_pb : '0;
	assign res.palette_entries = give_ok ? n_cc : '0;

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q         <= '0;
			field_accum_q        <= '0;
			header_offset_q      <= '0;
			image_width_q        <= '0;
			image_height_q       <= '0;
			pixel_bytes_q        <= '0;
			color_count_q        <= '0;
			colors_bad_q         <= 1'b0;
			palette_byte_count_q <= '0;
			blue_latch_q         <= '0;
			all_gray_q           <= 1'b1;
			skip_count_q         <= '0;
			phase_q              <= PH_IDLE;
		end else if (step) begin
			byte_index_q         <= n_idx;
			field_accum_q        <= n_acc;
			header_offset_q      <= n_off;
			image_width_q        <= n_w;
			image_height_q       <= n_h;
			pixel_bytes_q        <= n_pb;
			color_count_q        <= n_cc;
			colors_bad_q         <= n_ccbad;
			palette_byte_count_q <= n_pbc;
			blue_latch_q         <= n_blue;
			all_gray_q           <= n_gray;
			skip_count_q         <= n_skip;
			phase_q              <= n_phase;
		end
	end

endmodule

>>> sv/bhp_out_buf.sv
`timescale 1ns / 1ps

module bhp_out_buf import bhp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    can_push,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	// Two-entry result queue: the head drives the output, the second entry
	// absorbs a result produced while the head is stalled.
	logic    head_valid_q, tail_valid_q;
	result_t head_q, tail_q;
	logic    pop;

	assign can_push  = !tail_valid_q;
	assign out_valid = head_valid_q;
	assign out_data  = head_q;
	assign pop       = head_valid_q && out_ready;

	// Queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				head_valid_q <= tail_valid_q || push;
				tail_valid_q <= tail_valid_q && push;
			end else if (push) begin
				head_valid_q <= 1'b1;
				tail_valid_q <= head_valid_q;
			end
		end
	end

	// Queue payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= tail_valid_q ? tail_q : push_data;
			if (push) begin
				tail_q <= push_data;
			end
		end else if (push) begin
			if (head_valid_q) begin
				tail_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

endmodule

>>> sv/bmp_header_parser.sv
`timescale 1ns / 1ps

// BMP header checker. Takes a file one byte per clock on byte_ch; a request
// with start_req set restarts parsing at that byte. The file header and the
// 40-byte info header are checked in file order, the palette is scanned for
// gray entries, and padding up to the data offset is skipped. Exactly one
// result per file is returned on result_ch: the first error, or success on
// the last byte before the data offset; later bytes are dropped until the
// next start. Each byte is handled in the cycle it is accepted; its result,
// if any, is registered into the output queue. Bytes are accepted every
// cycle, except while two results sit unread in the two-entry output queue.
// max_dimension resets to 16384 and is written through cfg_we/cfg_wdata.
module bmp_header_parser import bhp_pkg::*; #(
	parameter int MAX_COLORS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	bhp_in_if.sink      byte_ch,
	bhp_out_if.source   result_ch
);

	logic [15:0] max_dim_q;
	logic        step;
	logic        res_valid;
	logic        can_push;
	result_t     res;
	result_t     head;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= MAX_DIM_RESET;
		end else if (cfg_we) begin
			max_dim_q <= cfg_wdata;
		end
	end

	assign byte_ch.ready = can_push;
	assign step          = byte_ch.valid && can_push;

	bhp_parser #(
		.MAX_COLORS(MAX_COLORS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (byte_ch.data_byte),
		.start_req    (byte_ch.start_req),
		.max_dimension(max_dim_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	bhp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.can_push (can_push),
		.out_valid(result_ch.valid),
		.out_ready(result_ch.ready),
		.out_data (head)
	);

	assign result_ch.status          = head.status;
	assign result_ch.width           = head.width;
	assign result_ch.height          = head.height;
	assign result_ch.bytes_per_pixel = head.bytes_per_pixel;
	assign result_ch.palette_entries = head.palette_entries;

endmodule
